// ===== hw/rtl/mrd_pkg.sv =====
`default_nettype none

package mrd_pkg;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_MAP   = 3'd1,
        ACT_READ  = 3'd2,
        ACT_WRITE = 3'd3,
        ACT_PROBE = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNMAPPED = 3'd1,
        ST_ZERO     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        address;
        logic [32:0]        region_size;
        logic [3:0]         target_port;
        logic signed [63:0] write_value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic               hit;
        logic [2:0]         entry_index;
        logic [3:0]         routed_port;
        logic [31:0]        offset;
        logic               is_write;
        logic signed [63:0] forward_value;
    } t_out_beat;

    // Query and update request from the decode stage to the window table.
    typedef struct packed {
        logic        clear;
        logic        append;
        logic [31:0] addr;
        logic [32:0] size;
        logic [3:0]  port;
    } t_tbl_cmd;

    // Lookup results of the window table for the current query.
    typedef struct packed {
        logic        hit;
        logic [2:0]  hit_entry;
        logic [3:0]  hit_port;
        logic [31:0] hit_offset;
        logic        clash;
        logic [2:0]  clash_entry;
        logic        full;
        logic [2:0]  next_entry;
    } t_tbl_status;

endpackage

`default_nettype wire

// ===== hw/rtl/mrd_if.sv =====
`default_nettype none

interface mrd_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [31:0]        address;
    logic [32:0]        region_size;
    logic [3:0]         target_port;
    logic signed [63:0] write_value;

    modport source (
        output valid, action, address, region_size, target_port, write_value,
        input  ready
    );
    modport sink (
        input  valid, action, address, region_size, target_port, write_value,
        output ready
    );
endinterface

interface mrd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               hit;
    logic [2:0]         entry_index;
    logic [3:0]         routed_port;
    logic [31:0]        offset;
    logic               is_write;
    logic signed [63:0] forward_value;

    modport source (
        output valid, status, hit, entry_index, routed_port, offset, is_write,
               forward_value,
        input  ready
    );
    modport sink (
        input  valid, status, hit, entry_index, routed_port, offset, is_write,
               forward_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/mrd_window_table.sv =====
`default_nettype none

module mrd_window_table
    import mrd_pkg::*;
#(
    parameter int MAX_REGIONS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_tbl_cmd    i_cmd,
    output t_tbl_status      o_status
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [MAX_REGIONS-1:0] r_valid;
    logic [31:0]            r_base [MAX_REGIONS];
    logic [32:0]            r_len  [MAX_REGIONS];
    logic [3:0]             r_port [MAX_REGIONS];
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    logic [31:0]            diff   [MAX_REGIONS];
    logic [33:0]            w_end  [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] holds;
    logic [MAX_REGIONS-1:0] meets;
    logic [33:0]            q_end;
    logic [IW-1:0]          hit_idx;
    logic [IW-1:0]          clash_idx;
    logic [IW-1:0]          wr_idx;

    always_comb begin
        q_end = {2'b00, i_cmd.addr} + {1'b0, i_cmd.size};
        for (int i = 0; i < MAX_REGIONS; i++) begin
            diff[i]  = i_cmd.addr - r_base[i];
            w_end[i] = {2'b00, r_base[i]} + {1'b0, r_len[i]};
            holds[i] = r_valid[i] && (i_cmd.addr >= r_base[i]) &&
                       ({1'b0, diff[i]} < r_len[i]);
            meets[i] = r_valid[i] && ({2'b00, i_cmd.addr} < w_end[i]) &&
                       ({2'b00, r_base[i]} < q_end);
        end

        // Lowest matching entry wins; windows never overlap, so a lookup
        // has at most one match, but the overlap search reports the first.
        hit_idx   = '0;
        clash_idx = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (holds[i]) begin
                hit_idx = IW'(i);
            end
            if (meets[i]) begin
                clash_idx = IW'(i);
            end
        end

        wr_idx = r_count[IW-1:0];
        n_count = r_count + CW'(1);

        o_status.hit         = |holds;
        o_status.hit_entry   = 3'(hit_idx);
        o_status.hit_port    = r_port[hit_idx];
        o_status.hit_offset  = diff[hit_idx];
        o_status.clash       = |meets;
        o_status.clash_entry = 3'(clash_idx);
        o_status.full        = (r_count >= CW'(MAX_REGIONS));
        o_status.next_entry  = 3'(r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.append) begin
            r_valid[wr_idx] <= 1'b1;
            r_count         <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !i_cmd.clear) begin
            r_base[wr_idx] <= i_cmd.addr;
            r_len[wr_idx]  <= i_cmd.size;
            r_port[wr_idx] <= i_cmd.port;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmio_region_decoder_top.sv =====
`default_nettype none

// Memory-mapped address decoder with a table of up to MAX_REGIONS windows.
// Each request beat carries one action: clear empties the table, map checks
// a new window (zero size, overflow past 2^ADDR_BITS, overlap with an
// existing window, table full) and appends it, and read, write and probe
// report the window that holds the address, its target port and the offset.
// The block takes one beat per cycle while the result is not stalled, with
// one input register, one result register, and all window compares running in
// parallel between them. A map or clear updates the table at the edge its
// result is registered, so the very next beat already sees the change.
// A stalled result holds the pipeline; the input register still takes a
// beat while the result waits, but only while it is empty.

module mmio_region_decoder_top
    import mrd_pkg::*;
#(
    parameter int MAX_REGIONS = 8,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrd_in_if.sink     i_req,
    mrd_out_if.source  o_rsp
);

    localparam logic [63:0] SPACE     = 64'd1 << ADDR_BITS;
    localparam logic [31:0] ADDR_MASK = 32'(SPACE - 64'd1);

    t_in_beat    r_in;
    logic        r_in_v;
    t_out_beat   r_out;
    logic        r_out_v;
    t_out_beat   n_out;

    logic        adv;
    logic [31:0] addr;
    logic [33:0] map_end;
    t_tbl_cmd    tbl_cmd;
    t_tbl_status tbl_st;

    assign adv         = r_in_v && (!r_out_v || o_rsp.ready);
    assign i_req.ready = !r_in_v || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_req.valid && i_req.ready) begin
            r_in_v <= 1'b1;
        end else if (adv) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.action      <= i_req.action;
            r_in.address     <= i_req.address;
            r_in.region_size <= i_req.region_size;
            r_in.target_port <= i_req.target_port;
            r_in.write_value <= i_req.write_value;
        end
    end

    assign addr    = r_in.address & ADDR_MASK;
    assign map_end = {2'b00, addr} + {1'b0, r_in.region_size};

    mrd_window_table #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (tbl_cmd),
        .o_status (tbl_st)
    );

    always_comb begin
        n_out          = '0;
        tbl_cmd.clear  = 1'b0;
        tbl_cmd.append = 1'b0;
        tbl_cmd.addr   = addr;
        tbl_cmd.size   = r_in.region_size;
        tbl_cmd.port   = r_in.target_port;

        case (r_in.action)
            ACT_CLEAR: begin
                tbl_cmd.clear = adv;
            end
            ACT_MAP: begin
                if (r_in.region_size == 33'd0) begin
                    n_out.status = ST_ZERO;
                end else if ({30'd0, map_end} > SPACE) begin
                    n_out.status = ST_OVERFLOW;
                end else if (tbl_st.clash) begin
                    n_out.status      = ST_OVERLAP;
                    n_out.entry_index = tbl_st.clash_entry;
                end else if (tbl_st.full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.status      = ST_OK;
                    n_out.entry_index = tbl_st.next_entry;
                    n_out.routed_port = r_in.target_port;
                    tbl_cmd.append    = adv;
                end
            end
            ACT_READ, ACT_WRITE, ACT_PROBE: begin
                if (tbl_st.hit) begin
                    n_out.hit         = 1'b1;
                    n_out.entry_index = tbl_st.hit_entry;
                    n_out.routed_port = tbl_st.hit_port;
                    n_out.offset      = tbl_st.hit_offset;
                    if (r_in.action == ACT_WRITE) begin
                        n_out.is_write      = 1'b1;
                        n_out.forward_value = r_in.write_value;
                    end
                end else if (r_in.action != ACT_PROBE) begin
                    n_out.status = ST_UNMAPPED;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid         = r_out_v;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.hit           = r_out.hit;
    assign o_rsp.entry_index   = r_out.entry_index;
    assign o_rsp.routed_port   = r_out.routed_port;
    assign o_rsp.offset        = r_out.offset;
    assign o_rsp.is_write      = r_out.is_write;
    assign o_rsp.forward_value = r_out.forward_value;

    // A full input register facing a stalled result must not take a beat.
    a_no_accept_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_v && r_out_v && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while the pipeline is stalled");

    // Every beat that leaves the input register shows up as a result.
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_v)
        else $error("advanced beat produced no result");

    // A clear leaves an empty table behind it.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.action == ACT_CLEAR) |=>
            (!tbl_st.full && tbl_st.next_entry == 3'd0 && !tbl_st.hit))
        else $error("table not empty after clear");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    localparam int          NUM_WINDOWS    = 8;
    localparam int          RANDOM_BEATS   = 1800;
    // Far above the slowest legal run of about 2000 beats through random stalls.
    localparam int          CYCLE_LIMIT    = 200_000;
    localparam logic [2:0]  ACT_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_HI  = 3'd7;
    localparam logic [32:0] SPACE_TOP      = 33'h1_0000_0000;

    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        t_out_beat want;
    } t_row;

    typedef struct {
        logic [31:0] base;
        logic [32:0] len;
    } t_span;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycles;
    bit   steady;
    bit   row_fixed;
    t_out_beat row_want;

    // Window table as the decoder should hold it.
    logic        win_valid [NUM_WINDOWS];
    logic [31:0] win_base  [NUM_WINDOWS];
    logic [32:0] win_len   [NUM_WINDOWS];
    logic [3:0]  win_port  [NUM_WINDOWS];
    int          win_count;

    t_out_beat awaited_decodes[$];
    t_span     planned_spans[$];
    t_row      directed_rows[$];

    mrd_in_if  req_if ();
    mrd_out_if rsp_if ();

    mmio_region_decoder_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_in_beat beat_of(logic [2:0] act, logic [31:0] addr,
                                         logic [32:0] size, logic [3:0] port,
                                         logic [63:0] wval);
        t_in_beat b;
        b.action      = act;
        b.address     = addr;
        b.region_size = size;
        b.target_port = port;
        b.write_value = wval;
        return b;
    endfunction

    function automatic t_out_beat result_of(logic [2:0] st, logic hit, logic [2:0] idx,
                                            logic [3:0] port, logic [31:0] off);
        t_out_beat r;
        r               = '0;
        r.status        = st;
        r.hit           = hit;
        r.entry_index   = idx;
        r.routed_port   = port;
        r.offset        = off;
        return r;
    endfunction

    function automatic void add_row(t_in_beat b, bit fixed, t_out_beat want);
        t_row row;
        row.beat      = b;
        row.fixed     = fixed;
        row.want      = want;
        directed_rows = {directed_rows, row};
    endfunction

    // Applies one request to the window table and returns the decode it should produce.
    function automatic t_out_beat decode_request(t_in_beat b);
        t_out_beat   r;
        logic [32:0] new_end;
        logic [32:0] old_end;
        logic [31:0] rel;
        bit          found;
        r     = '0;
        found = 1'b0;
        case (b.action)
            ACT_CLEAR: begin
                foreach (win_valid[i]) win_valid[i] = 1'b0;
                win_count = 0;
            end
            ACT_MAP: begin
                if (b.region_size == '0) begin
                    r.status = ST_ZERO;
                end else if ({2'b0, b.address} + {1'b0, b.region_size} > {1'b0, SPACE_TOP}) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    new_end = {1'b0, b.address} + b.region_size;
                    for (int i = 0; i < NUM_WINDOWS; i++) begin
                        old_end = {1'b0, win_base[i]} + win_len[i];
                        if (!found && win_valid[i] && {1'b0, b.address} < old_end &&
                            {1'b0, win_base[i]} < new_end) begin
                            found         = 1'b1;
                            r.status      = ST_OVERLAP;
                            r.entry_index = 3'(i);
                        end
                    end
                    if (!found) begin
                        if (win_count >= NUM_WINDOWS) begin
                            r.status = ST_FULL;
                        end else begin
                            win_valid[win_count] = 1'b1;
                            win_base[win_count]  = b.address;
                            win_len[win_count]   = b.region_size;
                            win_port[win_count]  = b.target_port;
                            r.entry_index        = 3'(win_count);
                            r.routed_port        = b.target_port;
                            win_count++;
                        end
                    end
                end
            end
            ACT_READ, ACT_WRITE, ACT_PROBE: begin
                for (int i = 0; i < NUM_WINDOWS; i++) begin
                    rel = b.address - win_base[i];
                    if (!found && win_valid[i] && b.address >= win_base[i] &&
                        {1'b0, rel} < win_len[i]) begin
                        found         = 1'b1;
                        r.hit         = 1'b1;
                        r.entry_index = 3'(i);
                        r.routed_port = win_port[i];
                        r.offset      = rel;
                    end
                end
                if (!found) begin
                    if (b.action != ACT_PROBE) r.status = ST_UNMAPPED;
                end else if (b.action == ACT_WRITE) begin
                    r.is_write      = 1'b1;
                    r.forward_value = b.write_value;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mostly windows and accesses that land on or around them, with some noise mixed in.
    function automatic t_in_beat pick_random_beat();
        t_in_beat    b;
        t_span       s;
        logic [63:0] off;
        int          r;
        b = beat_of(ACT_PROBE, $urandom, {1'($urandom), 32'($urandom)}, 4'($urandom),
                    {$urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 2) begin
            b.action = ACT_CLEAR;
            planned_spans.delete();
        end else if (r < 22) begin
            b.action = ACT_MAP;
            case ($urandom_range(0, 3))
                0: b.address = 32'($urandom_range(0, 32'hFFFF));
                1: if (planned_spans.size() > 0) begin
                    s = planned_spans[$urandom_range(0, planned_spans.size() - 1)];
                    b.address = s.base + 32'($urandom_range(0, 4)) - 32'd2;
                end
                2: b.address = 32'hFFFF_FFFF - 32'($urandom_range(0, 32'hFFFF));
                default: ;
            endcase
            r = $urandom_range(0, 99);
            if (r < 65)      b.region_size = 33'($urandom_range(1, 4096));
            else if (r < 80) b.region_size = 33'($urandom_range(1, 32'hFFFF_FFFF));
            else if (r < 85) b.region_size = '0;
            else if (r < 92) b.region_size = SPACE_TOP - b.address;
            else if (r < 97) b.region_size = SPACE_TOP - b.address + 33'd1;
            if (planned_spans.size() < 16) begin
                s.base        = b.address;
                s.len         = b.region_size;
                planned_spans = {planned_spans, s};
            end
        end else if (r < 30) begin
            b.action = 3'($urandom_range(0, 7));
            if (b.action == ACT_CLEAR) planned_spans.delete();
        end else begin
            case ($urandom_range(0, 2))
                0: b.action = ACT_READ;
                1: b.action = ACT_WRITE;
                default: b.action = ACT_PROBE;
            endcase
            if (planned_spans.size() > 0 && $urandom_range(0, 99) < 85) begin
                s = planned_spans[$urandom_range(0, planned_spans.size() - 1)];
                case ($urandom_range(0, 9))
                    0: off = '0;
                    1: off = 64'(s.len) - 64'd1;
                    2: off = 64'(s.len);
                    3: off = '1;
                    default: off = (s.len == '0) ? '0 : {$urandom, $urandom} % 64'(s.len);
                endcase
                b.address = 32'(64'(s.base) + off);
            end
        end
        return b;
    endfunction

    task automatic offer_beat(t_in_beat b, bit fixed, t_out_beat want);
        while (!steady && $urandom_range(0, 99) < 34) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= b.action;
        req_if.address     <= b.address;
        req_if.region_size <= b.region_size;
        req_if.target_port <= b.target_port;
        req_if.write_value <= b.write_value;
        row_fixed          <= fixed;
        row_want           <= want;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    initial begin
        t_in_beat b;
        int       sent;
        rst_n              = 1'b0;
        req_if.valid       = 1'b0;
        req_if.action      = '0;
        req_if.address     = '0;
        req_if.region_size = '0;
        req_if.target_port = '0;
        req_if.write_value = '0;
        rsp_if.ready       = 1'b0;
        steady             = 1'b0;
        row_fixed          = 1'b0;
        row_want           = '0;
        errors             = 0;
        win_count          = 0;
        foreach (win_valid[i]) win_valid[i] = 1'b0;

        add_row(beat_of(ACT_READ, 32'h0, '0, '0, '0), 1'b1,
                result_of(ST_UNMAPPED, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_PROBE, 32'hFFFF_FFFF, '0, '0, '0), 1'b1,
                result_of(ST_OK, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_MAP, 32'h0, '0, 4'h5, '0), 1'b1,
                result_of(ST_ZERO, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_MAP, 32'hFFFF_FFFF, 33'd2, 4'h5, '0), 1'b1,
                result_of(ST_OVERFLOW, 1'b0, '0, '0, '0));
        // One window covering the whole address space.
        add_row(beat_of(ACT_MAP, 32'h0, SPACE_TOP, 4'hF, '0), 1'b1,
                result_of(ST_OK, 1'b0, 3'd0, 4'hF, '0));
        add_row(beat_of(ACT_MAP, 32'h1000, 33'h10, 4'h3, '0), 1'b1,
                result_of(ST_OVERLAP, 1'b0, 3'd0, '0, '0));
        add_row(beat_of(ACT_READ, 32'hFFFF_FFFF, '0, '0, '0), 1'b1,
                result_of(ST_OK, 1'b1, 3'd0, 4'hF, 32'hFFFF_FFFF));
        add_row(beat_of(ACT_WRITE, 32'h8000_0000, '0, '0,
                        64'h8000_0000_0000_0000), 1'b0, '0);
        add_row(beat_of(ACT_CLEAR, '1, '1, '1, '1), 1'b1,
                result_of(ST_OK, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_WRITE, 32'h8000_0000, '0, '0, '1), 1'b1,
                result_of(ST_UNMAPPED, 1'b0, '0, '0, '0));
        // A window that ends exactly at the top of the address space.
        add_row(beat_of(ACT_MAP, 32'hFFFF_FFFF, 33'd1, 4'h0, '0), 1'b1,
                result_of(ST_OK, 1'b0, 3'd0, 4'h0, '0));
        add_row(beat_of(ACT_MAP, 32'h0, 33'd1, 4'h1, '0), 1'b0, '0);
        for (int k = 1; k <= 6; k++) begin
            add_row(beat_of(ACT_MAP, 32'(k * 32'h100), 33'h100, 4'(k + 1), '0), 1'b0, '0);
        end
        add_row(beat_of(ACT_MAP, 32'h1000, 33'h10, 4'h9, '0), 1'b1,
                result_of(ST_FULL, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_MAP, 32'h180, 33'd1, 4'h9, '0), 1'b1,
                result_of(ST_OVERLAP, 1'b0, 3'd2, '0, '0));
        add_row(beat_of(ACT_WRITE, 32'h6FF, '0, '0,
                        64'h7FFF_FFFF_FFFF_FFFF), 1'b0, '0);
        add_row(beat_of(ACT_WRITE, 32'h700, '0, '0, '1), 1'b1,
                result_of(ST_UNMAPPED, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_PROBE, 32'h345, '0, '0, '0), 1'b0, '0);
        add_row(beat_of(ACT_UNUSED_LO, '1, '1, '1, '1), 1'b1,
                result_of(ST_OK, 1'b0, '0, '0, '0));
        add_row(beat_of(ACT_UNUSED_HI, 32'h0, '0, '0, '0), 1'b1,
                result_of(ST_OK, 1'b0, '0, '0, '0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            steady <= (sent >= 600 && sent < 900);
            b = pick_random_beat();
            if (b.action <= ACT_PROBE) sent++;
            offer_beat(b, 1'b0, '0);
        end

        req_if.valid <= 1'b0;
        // The last beat is queued by the monitor at the edge it was taken.
        @(posedge clk);
        while (awaited_decodes.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("** mmio_region_decoder_top: PASSED **");
        end else begin
            $display("** mmio_region_decoder_top: FAILED **");
        end
        $finish;
    end

    always @(posedge clk) begin
        rsp_if.ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** mmio_region_decoder_top: FAILED **");
            $finish;
        end
    end

    initial cycles = 0;

    // The prediction is queued before the result check so that the order holds at any latency.
    always @(posedge clk) begin
        t_in_beat  b;
        t_out_beat predicted;
        t_out_beat want;
        t_out_beat got;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                b.action      = req_if.action;
                b.address     = req_if.address;
                b.region_size = req_if.region_size;
                b.target_port = req_if.target_port;
                b.write_value = req_if.write_value;
                predicted     = decode_request(b);
                if (row_fixed) predicted = row_want;
                awaited_decodes = {awaited_decodes, predicted};
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.status        = rsp_if.status;
                got.hit           = rsp_if.hit;
                got.entry_index   = rsp_if.entry_index;
                got.routed_port   = rsp_if.routed_port;
                got.offset        = rsp_if.offset;
                got.is_write      = rsp_if.is_write;
                got.forward_value = rsp_if.forward_value;
                if (awaited_decodes.size() == 0) begin
                    $error("result beat with no decode pending, status %0d", got.status);
                    errors++;
                end else begin
                    want = awaited_decodes.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("hit", 64'(want.hit), 64'(got.hit));
                    check_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
                    check_field("routed_port", 64'(want.routed_port), 64'(got.routed_port));
                    check_field("offset", 64'(want.offset), 64'(got.offset));
                    check_field("is_write", 64'(want.is_write), 64'(got.is_write));
                    check_field("forward_value", want.forward_value, got.forward_value);
                end
            end
        end
    end

endmodule

`default_nettype wire
